// ----- design/bto_pkg.sv -----
// Shared types, constants and the tanh table generator for the tanh overdrive.
package bto_pkg;

   localparam int SAMPLE_BITS_DEF  = 16;
   localparam int TANH_ENTRIES_DEF = 256;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_DRIVE_ENABLE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DRIVE_GAIN   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_DRIVE_BIAS   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_BIAS_OFFSET  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_NORM_SCALE   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_TONE_COEFF   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_WET_MIX      = 3'd6;

   // Tanh argument is signed Q.16; magnitudes from 4.0 upward saturate.
   localparam int ARG_W     = 22;
   localparam int MAG_W     = ARG_W - 1;
   localparam int ARG_LIM_B = 18;
   localparam int LUT_W     = 16;

   typedef struct packed {
      logic        drive_enable;
      logic [14:0] drive_gain;
      logic [11:0] drive_bias;
      logic [14:0] bias_offset;
      logic [14:0] norm_scale;
      logic [15:0] tone_coeff;
      logic [15:0] wet_mix;
   } cfg_type;

   typedef enum logic [2:0] {
      MUL_GAIN   = 3'd0,
      MUL_INTERP = 3'd1,
      MUL_NORM   = 3'd2,
      MUL_TONE   = 3'd3,
      MUL_MIX    = 3'd4
   } mul_op_type;

   typedef struct packed {
      logic       load_x;
      mul_op_type mul_op;
      logic       cap_arg;
      logic       rd_lo;
      logic       rd_hi;
      logic       cap_shape;
      logic       cap_y;
      logic       upd_tone;
      logic       cap_res;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic shaping_on;
      logic tone_on;
      logic out_free;
   } status_type;

   // Unsigned quotient by shift and subtract, used only while building the table.
   function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] quo;
      logic [64:0] rem;
      int          b;
      quo = '0;
      rem = '0;
      for (b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // One table entry from its position t = i * 2^32 / entries: odd series
   // on t/64, then six doublings of the argument in Q.30.
   function automatic logic [LUT_W-1:0] tanh_entry(input logic [63:0] t);
      logic [63:0] one;
      logic [63:0] y;
      logic [63:0] y2;
      logic [63:0] y3;
      logic [63:0] y5;
      logic [63:0] th;
      logic [63:0] den;
      logic [63:0] e;
      int          k;
      one = 64'd1 << 30;
      y   = t >> 6;
      y2  = (y * y) >> 30;
      y3  = (y2 * y) >> 30;
      y5  = (y3 * y2) >> 30;
      th  = y - udiv(y3, 64'd3) + udiv(64'd2 * y5, 64'd15);
      for (k = 0; k < 6; k++) begin
         den = one + ((th * th) >> 30);
         th  = udiv(th << 31, den);
      end
      e = (th + (64'd1 << 14)) >> 15;
      return (e > 64'd32768) ? 16'd32768 : e[LUT_W-1:0];
   endfunction

endpackage

// ----- design/bto_csr.sv -----
// Configuration register file of the tanh overdrive.
module bto_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bto_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bto_pkg::CSR_DATA_W-1:0]     csr_data,
   output bto_pkg::cfg_type                   cfg
);

   localparam logic [14:0] GAIN_RST = 15'd4096;
   localparam logic [14:0] NORM_RST = 15'd21520;
   localparam logic [15:0] TONE_RST = 16'd32768;
   localparam logic [15:0] WET_RST  = 16'd32768;

   bto_pkg::cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.drive_enable <= 1'b0;
         cfg_ff.drive_gain   <= GAIN_RST;
         cfg_ff.drive_bias   <= 12'd0;
         cfg_ff.bias_offset  <= 15'd0;
         cfg_ff.norm_scale   <= NORM_RST;
         cfg_ff.tone_coeff   <= TONE_RST;
         cfg_ff.wet_mix      <= WET_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            bto_pkg::REG_DRIVE_ENABLE: cfg_ff.drive_enable <= csr_data[0];
            bto_pkg::REG_DRIVE_GAIN:   cfg_ff.drive_gain   <= csr_data[14:0];
            bto_pkg::REG_DRIVE_BIAS:   cfg_ff.drive_bias   <= csr_data[11:0];
            bto_pkg::REG_BIAS_OFFSET:  cfg_ff.bias_offset  <= csr_data[14:0];
            bto_pkg::REG_NORM_SCALE:   cfg_ff.norm_scale   <= csr_data[14:0];
            bto_pkg::REG_TONE_COEFF:   cfg_ff.tone_coeff   <= csr_data[15:0];
            bto_pkg::REG_WET_MIX:      cfg_ff.wet_mix      <= csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

endmodule

// ----- design/bto_ctrl.sv -----
// Sequencing state machine of the tanh overdrive.
module bto_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  bto_pkg::status_type status,
   output bto_pkg::cmd_type    cmd
);

   typedef enum logic [13:0] {
      ST_IDLE     = 14'b00000000000001,
      ST_GAIN     = 14'b00000000000010,
      ST_ARG      = 14'b00000000000100,
      ST_LO       = 14'b00000000001000,
      ST_HI       = 14'b00000000010000,
      ST_INTERP   = 14'b00000000100000,
      ST_SHAPE    = 14'b00000001000000,
      ST_NORM     = 14'b00000010000000,
      ST_NORM_RND = 14'b00000100000000,
      ST_TONE     = 14'b00001000000000,
      ST_TONE_RND = 14'b00010000000000,
      ST_MIX      = 14'b00100000000000,
      ST_MIX_RND  = 14'b01000000000000,
      ST_OUT      = 14'b10000000000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.mul_op = bto_pkg::MUL_GAIN;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_x = 1'b1;
               state_in   = status.shaping_on ? ST_GAIN : ST_OUT;
            end
         end
         ST_GAIN: begin
            cmd.mul_op = bto_pkg::MUL_GAIN;
            state_in   = ST_ARG;
         end
         ST_ARG: begin
            cmd.cap_arg = 1'b1;
            state_in    = ST_LO;
         end
         ST_LO: begin
            cmd.rd_lo = 1'b1;
            state_in  = ST_HI;
         end
         ST_HI: begin
            cmd.rd_hi = 1'b1;
            state_in  = ST_INTERP;
         end
         ST_INTERP: begin
            cmd.mul_op = bto_pkg::MUL_INTERP;
            state_in   = ST_SHAPE;
         end
         ST_SHAPE: begin
            cmd.cap_shape = 1'b1;
            state_in      = ST_NORM;
         end
         ST_NORM: begin
            cmd.mul_op = bto_pkg::MUL_NORM;
            state_in   = ST_NORM_RND;
         end
         ST_NORM_RND: begin
            cmd.cap_y = 1'b1;
            state_in  = status.tone_on ? ST_TONE : ST_MIX;
         end
         ST_TONE: begin
            cmd.mul_op = bto_pkg::MUL_TONE;
            state_in   = ST_TONE_RND;
         end
         ST_TONE_RND: begin
            cmd.upd_tone = 1'b1;
            state_in     = ST_MIX;
         end
         ST_MIX: begin
            cmd.mul_op = bto_pkg::MUL_MIX;
            state_in   = ST_MIX_RND;
         end
         ST_MIX_RND: begin
            cmd.cap_res = 1'b1;
            state_in    = ST_OUT;
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- design/bto_dpath.sv -----
// Datapath of the tanh overdrive: shared multiplier, tanh table, filter and output register.
module bto_dpath #(
   parameter int SAMPLE_BITS  = bto_pkg::SAMPLE_BITS_DEF,
   parameter int TANH_ENTRIES = bto_pkg::TANH_ENTRIES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bto_pkg::cfg_type              cfg,
   input  bto_pkg::cmd_type              cmd,
   output bto_pkg::status_type           status,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,
   input  logic                          rsp_stall,
   output logic                          rsp_valid,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out
);

   localparam int SB     = SAMPLE_BITS;
   localparam int SB1    = SB + 1;
   localparam int FB     = SB - 1;
   localparam int MA_W   = (SB1 > 18) ? SB1 : 18;
   localparam int P_W    = MA_W + 17;
   localparam int GS     = FB - 4;
   localparam int IDX_W  = $clog2(TANH_ENTRIES);
   localparam int ROM_AW = $clog2(TANH_ENTRIES + 1);
   localparam int POS_W  = bto_pkg::ARG_LIM_B + IDX_W;
   localparam int LW     = bto_pkg::LUT_W;
   localparam int TH_W   = LW + 2;

   localparam logic signed [P_W-1:0] G_HALF = P_W'(2 ** (GS - 1));
   localparam logic signed [P_W-1:0] Q_HALF = P_W'(2 ** 14);
   localparam logic signed [P_W-1:0] SAT_HI = P_W'((64'sd1 <<< FB) - 64'sd1);
   localparam logic signed [P_W-1:0] SAT_LO = P_W'(-(64'sd1 <<< FB));
   localparam logic [LW:0]           TANH_ONE = 17'd32768;

   function automatic logic signed [SB-1:0] sat_s(input logic signed [P_W-1:0] v);
      return (v > SAT_HI) ? SB'(SAT_HI) : ((v < SAT_LO) ? SB'(SAT_LO) : SB'(v));
   endfunction

   function automatic logic signed [P_W-1:0] rnd15(input logic signed [P_W-1:0] v);
      return (v + Q_HALF) >>> 15;
   endfunction

   // Tanh table at 4*i/TANH_ENTRIES, unsigned Q1.15.
   logic [LW-1:0] rom [0:TANH_ENTRIES];

   for (genvar g = 0; g <= TANH_ENTRIES; g++) begin : g_rom
      localparam logic [63:0]   T_POS = (64'(g) << 32) / TANH_ENTRIES;
      localparam logic [LW-1:0] ENTRY = bto_pkg::tanh_entry(T_POS);
      assign rom[g] = ENTRY;
   end

   logic signed [SB-1:0]    x_ff;
   logic signed [SB-1:0]    res_ff;
   logic signed [SB-1:0]    y_ff;
   logic signed [SB-1:0]    tone_state_ff;
   logic signed [P_W-1:0]   prod_ff;
   logic                    big_ff;
   logic                    neg_ff;
   logic [IDX_W-1:0]        idx_ff;
   logic [LW-1:0]           frac_ff;
   logic [LW-1:0]           lo_ff;
   logic [LW-1:0]           hi_ff;
   logic signed [TH_W-1:0]  thb_ff;
   logic                    rsp_valid_ff;
   logic signed [SB-1:0]    rsp_sample_ff;

   logic signed [MA_W-1:0]  a_op;
   logic [LW-1:0]           b_op;
   logic signed [P_W-1:0]   a_ext;
   logic signed [P_W-1:0]   b_ext;
   logic signed [P_W-1:0]   prod_in;
   logic signed [SB1-1:0]   tone_diff;
   logic signed [SB1-1:0]   mix_diff;
   logic [LW-1:0]           mix_m;
   logic [LW-1:0]           lut_d;

   logic signed [P_W-1:0]   g_sh;
   logic signed [bto_pkg::ARG_W-1:0] arg;
   logic                    arg_neg;
   logic [bto_pkg::MAG_W-1:0] mag;
   logic                    arg_big;
   logic [POS_W-1:0]        pos_full;
   logic [IDX_W-1:0]        idx_in;

   logic [ROM_AW-1:0]       rom_addr;
   logic [32:0]             ip_sum;
   logic [LW:0]             r_mag;
   logic signed [TH_W-1:0]  th;
   logic signed [TH_W-1:0]  thb_in;
   logic signed [P_W-1:0]   n_rnd;
   logic signed [P_W-1:0]   t_sum;
   logic signed [P_W-1:0]   m_sum;

   assign status.shaping_on = cfg.drive_enable;
   assign status.tone_on    = ~cfg.tone_coeff[15];
   assign status.out_free   = ~rsp_valid_ff | ~rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;

   // Shared multiplier.
   assign tone_diff = SB1'(y_ff) - SB1'(tone_state_ff);
   assign mix_diff  = SB1'(y_ff) - SB1'(x_ff);
   assign mix_m     = cfg.wet_mix[15] ? 16'd32768 : cfg.wet_mix;
   assign lut_d     = (hi_ff >= lo_ff) ? (hi_ff - lo_ff) : '0;

   always_comb begin
      case (cmd.mul_op)
         bto_pkg::MUL_GAIN: begin
            a_op = MA_W'(x_ff);
            b_op = {1'b0, cfg.drive_gain};
         end
         bto_pkg::MUL_INTERP: begin
            a_op = $signed(MA_W'(lut_d));
            b_op = frac_ff;
         end
         bto_pkg::MUL_NORM: begin
            a_op = MA_W'(thb_ff);
            b_op = {1'b0, cfg.norm_scale};
         end
         bto_pkg::MUL_TONE: begin
            a_op = MA_W'(tone_diff);
            b_op = cfg.tone_coeff;
         end
         bto_pkg::MUL_MIX: begin
            a_op = MA_W'(mix_diff);
            b_op = mix_m;
         end
         default: begin
            a_op = '0;
            b_op = '0;
         end
      endcase
   end

   assign a_ext   = P_W'(a_op);
   assign b_ext   = P_W'($signed({1'b0, b_op}));
   assign prod_in = a_ext * b_ext;

   // Tanh argument in Q.16, its magnitude and the table position.
   assign g_sh     = (prod_ff + G_HALF) >>> GS;
   assign arg      = bto_pkg::ARG_W'(g_sh)
                   + $signed(bto_pkg::ARG_W'({cfg.drive_bias, 4'b0000}));
   assign arg_neg  = arg[bto_pkg::ARG_W-1];
   assign mag      = bto_pkg::MAG_W'(arg_neg ? -arg : arg);
   assign arg_big  = |mag[bto_pkg::MAG_W-1:bto_pkg::ARG_LIM_B];
   assign pos_full = POS_W'(mag[bto_pkg::ARG_LIM_B-1:0]) * POS_W'(TANH_ENTRIES);
   assign idx_in   = arg_big ? '0 : pos_full[bto_pkg::ARG_LIM_B +: IDX_W];

   assign rom_addr = ROM_AW'(idx_ff) + ROM_AW'(cmd.rd_hi);

   // Interpolated tanh, sign restored, bias offset removed.
   assign ip_sum = {1'b0, prod_ff[31:0]} + 33'd32768;
   assign r_mag  = big_ff ? TANH_ONE : (17'(lo_ff) + ip_sum[32:16]);
   assign th     = neg_ff ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag});
   assign thb_in = th - $signed(TH_W'(cfg.bias_offset));

   // Shaped value is Q.29; bring it to the sample format.
   if (FB < 29) begin : g_nrm_rs
      localparam int                    NS     = 29 - FB;
      localparam logic signed [P_W-1:0] N_HALF = P_W'(2 ** (NS - 1));
      assign n_rnd = (prod_ff + N_HALF) >>> NS;
   end else begin : g_nrm_ls
      assign n_rnd = prod_ff <<< (FB - 29);
   end

   assign t_sum = P_W'(tone_state_ff) + rnd15(prod_ff);
   assign m_sum = P_W'(x_ff) + rnd15(prod_ff);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (cmd.load_x) begin
         x_ff   <= req_sample_in;
         res_ff <= req_sample_in;
      end
      if (cmd.cap_arg) begin
         big_ff  <= arg_big;
         neg_ff  <= arg_neg;
         idx_ff  <= idx_in;
         frac_ff <= pos_full[bto_pkg::ARG_LIM_B-1:2];
      end
      if (cmd.rd_lo) begin
         lo_ff <= rom[rom_addr];
      end
      if (cmd.rd_hi) begin
         hi_ff <= rom[rom_addr];
      end
      if (cmd.cap_shape) begin
         thb_ff <= thb_in;
      end
      if (cmd.cap_y) begin
         y_ff <= sat_s(n_rnd);
      end else if (cmd.upd_tone) begin
         y_ff <= sat_s(t_sum);
      end
      if (cmd.cap_res) begin
         res_ff <= sat_s(m_sum);
      end
      if (cmd.out_load) begin
         rsp_sample_ff <= res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tone_state_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.upd_tone) begin
            tone_state_ff <= sat_s(t_sum);
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

// ----- design/biased_tanh_overdrive.sv -----
// A beat goes through gain, table read, interpolation, normalising, tone filter if on, and mix;
// with shaping off it goes straight to the output. No new beat is taken until the last is loaded.
// The rate is set by one shared multiplier used for up to five dependent products in sequence.
// The result register lets the next beat enter while a finished result waits.
// Synchronous reset restores the register defaults, clears the tone state and empties the output.
module biased_tanh_overdrive #(
   parameter int SAMPLE_BITS  = bto_pkg::SAMPLE_BITS_DEF,
   parameter int TANH_ENTRIES = bto_pkg::TANH_ENTRIES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic signed [SAMPLE_BITS-1:0]   req_sample_in,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]   rsp_sample_out,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bto_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bto_pkg::CSR_DATA_W-1:0]  csr_data
);

   bto_pkg::cfg_type    cfg;
   bto_pkg::cmd_type    cmd;
   bto_pkg::status_type status;

   bto_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   bto_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bto_dpath #(
      .SAMPLE_BITS  (SAMPLE_BITS),
      .TANH_ENTRIES (TANH_ENTRIES)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .cmd            (cmd),
      .status         (status),
      .req_sample_in  (req_sample_in),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_sample_out (rsp_sample_out)
   );

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("Result loaded while the output register still holds an untaken beat.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("Input not stalled while a beat is in progress.");

   a_load_shows_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid)
      else $error("Loaded result not presented on the output.");

endmodule
